/* rtl/twrtc_pkg.sv */
// ----------------------------------------------------------------------------
// twrtc_pkg
// shared types, phase codes and bcd helpers for the three-wire rtc master
// ----------------------------------------------------------------------------
package twrtc_pkg;

    localparam int BYTE_BITS = 8;
    localparam int IDX_W     = $clog2(BYTE_BITS);
    localparam int PHASE_W   = 3;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD_LO = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CMD_HI = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WR_LO  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WR_HI  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RD_LO  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_RD_HI  = 3'd6;

    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(BYTE_BITS - 1);

    typedef struct packed {
        logic [PHASE_W-1:0]   phase;
        logic [IDX_W-1:0]     bit_idx;
        logic                 is_read;
        logic [BYTE_BITS-1:0] cmd_byte;
        logic [BYTE_BITS-1:0] data_byte;
        logic [BYTE_BITS-1:0] rx_shift;
        logic [7:0]           read_value;
    } t_state;

    typedef struct packed {
        logic       start_req;
        logic       mode;
        logic [7:0] address;
        logic [6:0] write_value;
        logic       io_in;
    } t_item;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
    } t_result;

    // clamp at 99, then split into tens and units
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [6:0]  c;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        c     = (v > 7'd99) ? 7'd99 : v;
        prod  = 15'(c) * 15'd205;
        tens  = prod[14:11];
        units = c - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
        return {tens, units[3:0]};
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4] & 4'hf};
        return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
    endfunction

endpackage

/* rtl/three_wire_rtc_serial_master.sv */
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// each input transfer's result is held in the output register from the next cycle
// throughput: one tick per cycle, sustained while the result side takes data
// the sequencer state and the output register sit behind a single logic pass
// reset: synchronous active low, sequencer idle, read value 0, no result held
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master
    import twrtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // start_req, mode, address[7:0], write_value[6:0], io_in, zero pad
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // chip_enable, serial_clock, io_out, io_drive, busy_res, done_res,
    // read_value[7:0], zero pad
    output logic [15:0] o_m_axis_tdata
);

    t_state  r_state;
    t_state  n_state;
    t_item   item;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_xfer;

    assign item.start_req   = i_s_axis_tdata[0];
    assign item.mode        = i_s_axis_tdata[1];
    assign item.address     = i_s_axis_tdata[9:2];
    assign item.write_value = i_s_axis_tdata[16:10];
    assign item.io_in       = i_s_axis_tdata[17];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    twrtc_step u_step (
        .i_state  (r_state),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_result.read_value, r_result.done_res,
                              r_result.busy_res, r_result.io_drive, r_result.io_out,
                              r_result.serial_clock, r_result.chip_enable};

    // a start on an idle tick always opens the command phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (r_state.phase == PH_IDLE) && item.start_req)
            |=> (r_state.phase == PH_CMD_LO))
        else $error("start did not open command phase");

    // done is only reported on the tick that releases chip enable
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_result.done_res) |-> !r_result.chip_enable)
        else $error("done with chip enable still high");

    // a held result is never overwritten by a new transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !in_xfer)
        else $error("result overwritten while stalled");

    // the sequencer only moves on an input transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_state))
        else $error("state changed without a transfer");

endmodule

/* rtl/twrtc_step.sv */
// ----------------------------------------------------------------------------
// twrtc_step
// one half-bit tick of the link: next sequencer state and the line levels
// ----------------------------------------------------------------------------
module twrtc_step
    import twrtc_pkg::*;
(
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state n_st;
    logic   done;

    always_comb begin
        n_st = i_state;
        done = 1'b0;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    n_st.is_read   = i_item.mode;
                    n_st.cmd_byte  = i_item.mode ? i_item.address + 8'd1 : i_item.address;
                    n_st.data_byte = to_bcd(i_item.write_value);
                    n_st.rx_shift  = '0;
                    n_st.bit_idx   = '0;
                    n_st.phase     = PH_CMD_LO;
                end
            end
            PH_CMD_LO: n_st.phase = PH_CMD_HI;
            PH_CMD_HI: begin
                if (i_state.bit_idx != LAST_BIT) begin
                    n_st.bit_idx = i_state.bit_idx + 1'b1;
                    n_st.phase   = PH_CMD_LO;
                end else begin
                    n_st.bit_idx = '0;
                    if (i_state.is_read) begin
                        n_st.phase       = PH_RD_LO;
                        n_st.rx_shift[0] = i_state.rx_shift[0] | i_item.io_in;
                    end else begin
                        n_st.phase = PH_WR_LO;
                    end
                end
            end
            PH_WR_LO: n_st.phase = PH_WR_HI;
            PH_WR_HI: begin
                if (i_state.bit_idx != LAST_BIT) begin
                    n_st.bit_idx = i_state.bit_idx + 1'b1;
                    n_st.phase   = PH_WR_LO;
                end else begin
                    n_st.phase   = PH_IDLE;
                    n_st.bit_idx = '0;
                    done         = 1'b1;
                end
            end
            PH_RD_LO: begin
                if (i_state.bit_idx != LAST_BIT) begin
                    n_st.phase = PH_RD_HI;
                end else begin
                    n_st.read_value = from_bcd(i_state.rx_shift);
                    n_st.phase      = PH_IDLE;
                    n_st.bit_idx    = '0;
                    done            = 1'b1;
                end
            end
            PH_RD_HI: begin
                n_st.bit_idx                = i_state.bit_idx + 1'b1;
                n_st.phase                  = PH_RD_LO;
                n_st.rx_shift[n_st.bit_idx] = i_state.rx_shift[n_st.bit_idx] | i_item.io_in;
            end
            default: begin
                n_st.phase   = PH_IDLE;
                n_st.bit_idx = '0;
            end
        endcase
    end

    always_comb begin
        o_state               = n_st;
        o_result.chip_enable  = (n_st.phase != PH_IDLE);
        o_result.serial_clock = (n_st.phase == PH_CMD_HI) || (n_st.phase == PH_WR_HI)
                             || (n_st.phase == PH_RD_HI);
        o_result.io_drive     = !((n_st.phase == PH_RD_LO) || (n_st.phase == PH_RD_HI));
        o_result.busy_res     = (n_st.phase != PH_IDLE);
        o_result.done_res     = done;
        o_result.read_value   = n_st.read_value;
        if ((n_st.phase == PH_CMD_LO) || (n_st.phase == PH_CMD_HI)) begin
            o_result.io_out = n_st.cmd_byte[n_st.bit_idx];
        end else if ((n_st.phase == PH_WR_LO) || (n_st.phase == PH_WR_HI)) begin
            o_result.io_out = n_st.data_byte[n_st.bit_idx];
        end else begin
            o_result.io_out = 1'b0;
        end
    end

endmodule

/* test/rtc_link_checker.sv */
// ----------------------------------------------------------------------------
// rtc_link_checker
// watches both stream channels of the three-wire rtc master, runs a
// cycle-true copy of the link sequencer on every accepted tick and compares
// each returned pin/status transfer with the oldest expected one
// ----------------------------------------------------------------------------
module rtc_link_checker
    import twrtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // start_req, mode, address[7:0], write_value[6:0], io_in, zero pad
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // chip_enable, serial_clock, io_out, io_drive, busy_res, done_res,
    // read_value[7:0], zero pad
    input  logic [15:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PHASE_W-1:0] link_phase;
    int unsigned        bit_pos;
    logic               rd_txn;
    logic [7:0]         cmd_shadow;
    logic [7:0]         wr_bcd;
    logic [7:0]         rx_byte;
    logic [7:0]         last_read;

    t_result expected_pins_q[$];

    function automatic logic [7:0] pack_bcd_clamped(input logic [6:0] v);
        int unsigned c;
        c = (v > 7'd99) ? 99 : int'(v);
        return 8'(((c / 10) << 4) | (c % 10));
    endfunction

    function automatic logic [7:0] unpack_bcd(input logic [7:0] b);
        return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < 100) begin
            $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    task automatic advance_link(input t_item tick, output t_result pins);
        logic done;
        done = 1'b0;
        case (link_phase)
            PH_IDLE: begin
                if (tick.start_req) begin
                    rd_txn     = tick.mode;
                    cmd_shadow = tick.mode ? 8'(tick.address + 8'd1) : tick.address;
                    wr_bcd     = pack_bcd_clamped(tick.write_value);
                    rx_byte    = '0;
                    bit_pos    = 0;
                    link_phase = PH_CMD_LO;
                end
            end
            PH_CMD_LO: link_phase = PH_CMD_HI;
            PH_CMD_HI: begin
                if (bit_pos < BYTE_BITS - 1) begin
                    bit_pos++;
                    link_phase = PH_CMD_LO;
                end else begin
                    bit_pos = 0;
                    if (rd_txn) begin
                        link_phase = PH_RD_LO;
                        if (tick.io_in) rx_byte[bit_pos % 8] = 1'b1;
                    end else begin
                        link_phase = PH_WR_LO;
                    end
                end
            end
            PH_WR_LO: link_phase = PH_WR_HI;
            PH_WR_HI: begin
                if (bit_pos < BYTE_BITS - 1) begin
                    bit_pos++;
                    link_phase = PH_WR_LO;
                end else begin
                    link_phase = PH_IDLE;
                    bit_pos    = 0;
                    done       = 1'b1;
                end
            end
            PH_RD_LO: begin
                if (bit_pos < BYTE_BITS - 1) begin
                    link_phase = PH_RD_HI;
                end else begin
                    last_read  = unpack_bcd(rx_byte);
                    link_phase = PH_IDLE;
                    bit_pos    = 0;
                    done       = 1'b1;
                end
            end
            PH_RD_HI: begin
                bit_pos++;
                link_phase = PH_RD_LO;
                if (tick.io_in) rx_byte[bit_pos % 8] = 1'b1;
            end
            default: begin
                link_phase = PH_IDLE;
                bit_pos    = 0;
            end
        endcase

        pins.chip_enable  = (link_phase != PH_IDLE);
        pins.serial_clock = (link_phase == PH_CMD_HI) || (link_phase == PH_WR_HI)
                            || (link_phase == PH_RD_HI);
        pins.io_drive     = !((link_phase == PH_RD_LO) || (link_phase == PH_RD_HI));
        pins.io_out       = 1'b0;
        if ((link_phase == PH_CMD_LO) || (link_phase == PH_CMD_HI)) begin
            pins.io_out = cmd_shadow[bit_pos % 8];
        end else if ((link_phase == PH_WR_LO) || (link_phase == PH_WR_HI)) begin
            pins.io_out = wr_bcd[bit_pos % 8];
        end
        pins.busy_res   = pins.chip_enable;
        pins.done_res   = done;
        pins.read_value = last_read;
    endtask

    always @(posedge i_clk) begin
        t_item   tick;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            link_phase = PH_IDLE;
            bit_pos    = 0;
            rd_txn     = 1'b0;
            cmd_shadow = '0;
            wr_bcd     = '0;
            rx_byte    = '0;
            last_read  = '0;
            expected_pins_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.chip_enable  = i_m_tdata[0];
                got.serial_clock = i_m_tdata[1];
                got.io_out       = i_m_tdata[2];
                got.io_drive     = i_m_tdata[3];
                got.busy_res     = i_m_tdata[4];
                got.done_res     = i_m_tdata[5];
                got.read_value   = i_m_tdata[13:6];
                if (expected_pins_q.size() == 0) begin
                    report_mismatch("result transfer with nothing pending, read_value",
                                    got.read_value, 0);
                end else begin
                    want = expected_pins_q.pop_front();
                    if (got.chip_enable !== want.chip_enable)
                        report_mismatch("chip_enable", got.chip_enable, want.chip_enable);
                    if (got.serial_clock !== want.serial_clock)
                        report_mismatch("serial_clock", got.serial_clock, want.serial_clock);
                    if (got.io_out !== want.io_out)
                        report_mismatch("io_out", got.io_out, want.io_out);
                    if (got.io_drive !== want.io_drive)
                        report_mismatch("io_drive", got.io_drive, want.io_drive);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                tick.start_req   = i_s_tdata[0];
                tick.mode        = i_s_tdata[1];
                tick.address     = i_s_tdata[9:2];
                tick.write_value = i_s_tdata[16:10];
                tick.io_in       = i_s_tdata[17];
                advance_link(tick, want);
                expected_pins_q.push_back(want);
            end
        end
        o_pending <= expected_pins_q.size();
    end

endmodule

/* test/three_wire_rtc_serial_master_tb.sv */
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_tb
// drives half-bit ticks into the rtc master: directed write and read
// transactions over the field extremes, then random ticks under several
// sender idle and receiver stall mixes; the checker does the comparison
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_TICKS  = 1120;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // start_req, mode, address[7:0], write_value[6:0], io_in, zero pad
    logic [23:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // chip_enable, serial_clock, io_out, io_drive, busy_res, done_res,
    // read_value[7:0], zero pad
    logic [15:0] o_m_axis_tdata;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int cycle_count;

    three_wire_rtc_serial_master u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    rtc_link_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [23:0] pack_tick(input logic start, input logic mode,
                                              input logic [7:0] addr,
                                              input logic [6:0] wval, input logic io);
        return {6'd0, io, wval, addr, mode, start};
    endfunction

    task automatic send_tick(input logic [23:0] word);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // one whole transaction; bus fields change at random while busy and
    // hold_start keeps the request raised through to the done tick
    task automatic run_transaction(input logic rd, input logic [7:0] addr,
                                   input logic [6:0] wval, input logic [7:0] rx_pattern,
                                   input logic hold_start);
        int  k;
        int  n_ticks;
        logic io;
        n_ticks = rd ? 31 : 32;
        send_tick(pack_tick(1'b1, rd, addr, wval, 1'($urandom_range(1))));
        for (k = 1; k <= n_ticks; k++) begin
            io = 1'($urandom_range(1));
            if (rd && k >= 16 && (k % 2) == 0) io = rx_pattern[(k - 16) / 2];
            send_tick(pack_tick(hold_start, 1'($urandom_range(1)),
                                8'($urandom_range(255)), 7'($urandom_range(127)), io));
        end
    endtask

    initial begin
        int n;
        int seg;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // value extremes, clamp above 99, address wrap on read, non-bcd byte
        run_transaction(1'b0, 8'h80, 7'd0,   8'h00, 1'b0);
        run_transaction(1'b0, 8'hff, 7'd99,  8'h00, 1'b1);
        run_transaction(1'b0, 8'h00, 7'd100, 8'h00, 1'b0);
        run_transaction(1'b0, 8'h5a, 7'd127, 8'h00, 1'b0);
        run_transaction(1'b1, 8'hff, 7'd0,   8'hff, 1'b1);
        run_transaction(1'b1, 8'h00, 7'd55,  8'h59, 1'b0);
        run_transaction(1'b1, 8'ha4, 7'd12,  8'h00, 1'b0);

        for (n = 0; n < RAND_TICKS; n++) begin
            seg = (n / 140) % 4;
            case (seg)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 52;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 52;
                end
                default: begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            send_tick(pack_tick($urandom_range(99) < 80, 1'($urandom_range(1)),
                                8'($urandom_range(255)), 7'($urandom_range(127)),
                                1'($urandom_range(1))));
        end
        i_s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/twrtc_pkg.sv
rtl/twrtc_step.sv
rtl/three_wire_rtc_serial_master.sv
test/rtc_link_checker.sv
test/three_wire_rtc_serial_master_tb.sv
